>>> rtl/core/mck_pkg.sv
// ----------------------------------------------------------------------------
// Morse keyer package
// Request and symbol types, symbol codes, timing units and the letter table.
// ----------------------------------------------------------------------------
package mck_pkg;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_message;
	} in_t;

	typedef struct packed {
		logic [1:0] symbol;
		logic [1:0] led_on_units;
		logic [2:0] off_units;
		logic       last_of_run;
	} out_t;

	localparam logic [1:0] SYM_DOT     = 2'd0;
	localparam logic [1:0] SYM_DASH    = 2'd1;
	localparam logic [1:0] SYM_SPACE   = 2'd2;
	localparam logic [1:0] SYM_NEWLINE = 2'd3;

	localparam logic [1:0] ON_NONE = 2'd0;
	localparam logic [1:0] ON_DOT  = 2'd1;
	localparam logic [1:0] ON_DASH = 2'd3;

	localparam logic [2:0] OFF_NONE   = 3'd0;
	localparam logic [2:0] OFF_INTRA  = 3'd1;
	localparam logic [2:0] OFF_WORD_A = 3'd2;
	localparam logic [2:0] OFF_LETTER = 3'd3;

	localparam logic [7:0] CHAR_SPACE    = 8'h20;
	localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
	localparam logic [7:0] CHAR_CASE_BIT = 8'h20;

	// Code words are read from the top bit: "1" dot, "111" dash, a single
	// "0" between elements and "00" at the end of the letter.
	function automatic logic [15:0] letter_code(input logic [4:0] idx);
		logic [15:0] code;
		unique case (idx)
			5'd0:  code = 16'hB800;
			5'd1:  code = 16'hEA80;
			5'd2:  code = 16'hEBA0;
			5'd3:  code = 16'hEA00;
			5'd4:  code = 16'h8000;
			5'd5:  code = 16'hAE80;
			5'd6:  code = 16'hEE80;
			5'd7:  code = 16'hAA00;
			5'd8:  code = 16'hA000;
			5'd9:  code = 16'hBBB8;
			5'd10: code = 16'hEB80;
			5'd11: code = 16'hBA80;
			5'd12: code = 16'hEE00;
			5'd13: code = 16'hE800;
			5'd14: code = 16'hEEE0;
			5'd15: code = 16'hBBA0;
			5'd16: code = 16'hEEB8;
			5'd17: code = 16'hBA00;
			5'd18: code = 16'hA800;
			5'd19: code = 16'hE000;
			5'd20: code = 16'hAE00;
			5'd21: code = 16'hAB80;
			5'd22: code = 16'hBB80;
			5'd23: code = 16'hEAE0;
			5'd24: code = 16'hEBB8;
			5'd25: code = 16'hEEA0;
			default: code = 16'h0000;
		endcase
		return code;
	endfunction

endpackage

>>> rtl/core/mck_seq.sv
// ----------------------------------------------------------------------------
// Morse keyer sequencer
// Takes one character and steps out its symbols, walking the code word
// through a shift register one element per cycle while sym_take is high.
// ----------------------------------------------------------------------------
module mck_seq (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         req_valid,
	output logic         req_ready,
	input  mck_pkg::in_t req,
	output logic         sym_valid,
	input  logic         sym_take,
	output mck_pkg::out_t sym
);

	typedef enum logic [2:0] {S_IDLE, S_GAP, S_SPACE, S_LETTER, S_NEWLINE} state_t;

	state_t      state_q;
	logic        after_letter_q;
	logic        eom_q;
	logic        letter_q;
	logic        gap_q;
	logic [15:0] code_q;
	logic [2:0]  cnt_q;

	logic        is_letter;
	logic        is_space;
	logic [7:0]  lower;
	logic [7:0]  idx;
	logic        is_dash;
	logic        elem_end;
	logic        cap_hit;
	logic        elem_fin;
	state_t      done_state;

	assign is_letter = ((req.character >= mck_pkg::CHAR_UPPER_A) &&
			(req.character <= mck_pkg::CHAR_UPPER_Z)) ||
			((req.character >= mck_pkg::CHAR_LOWER_A) &&
			(req.character <= mck_pkg::CHAR_LOWER_Z));
	assign is_space  = (req.character == mck_pkg::CHAR_SPACE);
	assign lower     = req.character | mck_pkg::CHAR_CASE_BIT;
	assign idx       = lower - mck_pkg::CHAR_LOWER_A;

	// The element is the last of the letter when the bits after its
	// separator begin the end marker; the count cap matches the five-result
	// limit on gap plus elements.
	assign is_dash  = code_q[14];
	assign elem_end = is_dash ? (code_q[12:11] == 2'b00) : !code_q[13];
	assign cap_hit  = gap_q ? (cnt_q == 3'd3) : (cnt_q == 3'd4);
	assign elem_fin = elem_end || cap_hit;

	assign done_state = eom_q ? S_NEWLINE : S_IDLE;
	assign req_ready  = (state_q == S_IDLE);

	always_comb begin
		sym_valid = 1'b0;
		sym       = '{mck_pkg::SYM_SPACE, mck_pkg::ON_NONE, mck_pkg::OFF_NONE, 1'b0};
		unique case (state_q)
			S_IDLE: begin
				sym_valid = 1'b0;
			end
			S_GAP: begin
				sym_valid = 1'b1;
				sym = '{mck_pkg::SYM_SPACE, mck_pkg::ON_NONE, mck_pkg::OFF_LETTER,
					!letter_q && !eom_q};
			end
			S_SPACE: begin
				sym_valid = 1'b1;
				sym = '{mck_pkg::SYM_SPACE, mck_pkg::ON_NONE,
					(cnt_q == 3'd2) ? mck_pkg::OFF_LETTER : mck_pkg::OFF_WORD_A,
					(cnt_q == 3'd2) && !eom_q};
			end
			S_LETTER: begin
				sym_valid = code_q[15];
				sym = '{is_dash ? mck_pkg::SYM_DASH : mck_pkg::SYM_DOT,
					is_dash ? mck_pkg::ON_DASH : mck_pkg::ON_DOT,
					elem_fin ? mck_pkg::OFF_NONE : mck_pkg::OFF_INTRA,
					elem_fin && !eom_q};
			end
			S_NEWLINE: begin
				sym_valid = 1'b1;
				sym = '{mck_pkg::SYM_NEWLINE, mck_pkg::ON_NONE, mck_pkg::OFF_NONE, 1'b1};
			end
			default: begin
				sym_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			after_letter_q <= 1'b0;
			eom_q          <= 1'b0;
			letter_q       <= 1'b0;
			gap_q          <= 1'b0;
			code_q         <= '0;
			cnt_q          <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						eom_q          <= req.end_of_message;
						letter_q       <= is_letter;
						gap_q          <= after_letter_q && !is_space;
						code_q         <= mck_pkg::letter_code(idx[4:0]);
						cnt_q          <= '0;
						after_letter_q <= is_letter && !req.end_of_message;
						priority if (after_letter_q && !is_space)
							state_q <= S_GAP;
						else if (is_space)
							state_q <= S_SPACE;
						else if (is_letter)
							state_q <= S_LETTER;
						else if (req.end_of_message)
							state_q <= S_NEWLINE;
						else
							state_q <= S_IDLE;
					end
				end
				S_GAP: begin
					if (sym_take) begin
						state_q <= letter_q ? S_LETTER : done_state;
					end
				end
				S_SPACE: begin
					if (sym_take) begin
						cnt_q <= cnt_q + 3'd1;
						if (cnt_q == 3'd2)
							state_q <= done_state;
					end
				end
				S_LETTER: begin
					if (!code_q[15]) begin
						if (code_q[14])
							code_q <= {code_q[14:0], 1'b0};
						else
							state_q <= done_state;
					end else if (sym_take) begin
						cnt_q <= cnt_q + 3'd1;
						if (elem_fin)
							state_q <= done_state;
						else if (!is_dash)
							code_q <= {code_q[13:0], 2'b00};
						else if (code_q[12])
							code_q <= {code_q[12:0], 3'b000};
						else
							code_q <= {code_q[11:0], 4'b0000};
					end
				end
				S_NEWLINE: begin
					if (sym_take)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/morse_code_keyer_top.sv
// ----------------------------------------------------------------------------
// Morse code keyer
// Turns a stream of ASCII characters into timed Morse symbols.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+---------------------------
//  char    | in        | char_valid, char_ready | char_data (mck_pkg::in_t)
//  sym     | out       | sym_valid, sym_ready   | sym_data (mck_pkg::out_t)
//
//  A character request is taken while the sequencer is idle; the sequencer
//  then issues one symbol per cycle unless sym_ready stalls it, up to 6 symbols
//  (letter gap, four elements and newline). A request with no symbol stays idle.
//  The code word is walked one element per cycle, barring stalls, in the
//  sequencer's shift register; separators are skipped within the same step.
//  A stall on sym_ready holds the sequencer; the output register lets the
//  next request enter while the last symbol still waits.
//  Reset clears the sequencer state, the output valid and the letter flag.
//
module morse_code_keyer_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_ready,
	input  mck_pkg::in_t  char_data,
	output logic          sym_valid,
	input  logic          sym_ready,
	output mck_pkg::out_t sym_data
);

	logic          seq_valid;
	logic          seq_take;
	mck_pkg::out_t seq_sym;
	logic          out_valid_q;
	mck_pkg::out_t out_q;

	// The sequencer advances whenever the output register is empty or its
	// symbol is leaving in this cycle.
	assign seq_take = seq_valid && (!out_valid_q || sym_ready);

	mck_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (char_valid),
		.req_ready (char_ready),
		.req       (char_data),
		.sym_valid (seq_valid),
		.sym_take  (seq_take),
		.sym       (seq_sym)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_take) begin
			out_valid_q <= 1'b1;
		end else if (sym_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_take)
			out_q <= seq_sym;
	end

	assign sym_valid = out_valid_q;
	assign sym_data  = out_q;

	// The sequencer never offers a symbol while it is free for a request.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		char_ready |-> !seq_valid)
		else $error("sequencer offers a symbol while idle");

	// A newline always closes the run of its request.
	a_newline_last: assert property (@(posedge clk) disable iff (!arst_n)
		seq_valid && (seq_sym.symbol == mck_pkg::SYM_NEWLINE) |-> seq_sym.last_of_run)
		else $error("newline symbol not marked last");

	// Only dots and dashes light the LED.
	a_led_only_marks: assert property (@(posedge clk) disable iff (!arst_n)
		seq_valid && (seq_sym.led_on_units != mck_pkg::ON_NONE) |->
		(seq_sym.symbol == mck_pkg::SYM_DOT) || (seq_sym.symbol == mck_pkg::SYM_DASH))
		else $error("LED time on a non-mark symbol");

	// A symbol that was taken while the register was full means one was lost.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		seq_take |-> !out_valid_q || sym_ready)
		else $error("output register overwritten");

endmodule
